// ===== src/assert_macros.svh =====
// Assertion macros shared by the modulator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== src/nspm_pkg.sv =====
// Package for the noise-shaped PWM modulator: types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package nspm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INTEG_W  = 32;
  localparam int LEVEL_SH = 8;
  localparam int DUTY_W   = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic REG_PWM_PERIOD = 1'b0;

  typedef struct packed {
    logic advance;
    logic update;
  } step_ctl_t;

endpackage

// ===== src/noise_shaped_pwm_modulator.sv =====
// Noise-shaped PWM modulator top level: input register, sub-step sequencing,
// result register and APB register port. Depends on nspm_pkg, nspm_integ and
// assert_macros.svh.
`timescale 1ns / 1ps

// Each accepted sample produces OVERSAMPLE duty values (six by default), one
// per clock while the result side does not stall; the four-integrator update
// for one sub-step is combinational between the held sample and the result
// register. The next sample is taken in the cycle its predecessor's last
// sub-step is issued, so samples stream with no gap. A silent sample gives
// half of pwm_period on every sub-step and leaves the integrators untouched.
// pwm_period sits at byte address 0 and resets to 0.
module noise_shaped_pwm_modulator #(
  parameter int OVERSAMPLE = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic signed [nspm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                silent,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic        [nspm_pkg::DUTY_W-1:0]   duty,
  output logic                                last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [nspm_pkg::ADDR_W-1:0]   paddr,
  input  logic        [nspm_pkg::DATA_W-1:0]   pwdata,
  output logic        [nspm_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);
  import nspm_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE - 1);

  logic [DUTY_W-1:0]          pwm_period;
  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic                       cur_silent;
  logic                       out_free;
  logic                       sub_last;
  logic                       accept;
  logic [DUTY_W-1:0]          level;
  logic [DUTY_W-1:0]          mid;
  step_ctl_t                  ctl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PWM_PERIOD) ? {{(DATA_W-DUTY_W){1'b0}}, pwm_period} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PWM_PERIOD)) begin
      pwm_period <= pwdata[DUTY_W-1:0];
    end
  end

  assign out_free    = !result_valid || !result_stall;
  assign ctl.advance = busy && out_free;
  assign ctl.update  = !cur_silent;
  assign sub_last    = (cnt == CNT_LAST);
  assign item_stall  = busy && !(ctl.advance && sub_last);
  assign accept      = item_valid && !item_stall;
  assign mid         = pwm_period >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (ctl.advance) begin
      busy <= !sub_last;
      cnt  <= sub_last ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= sample;
      cur_silent <= silent;
    end
  end

  nspm_integ u_integ (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (cur_sample),
    .level  (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= ctl.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      duty <= cur_silent ? mid : level + mid;
      last <= sub_last;
    end
  end

  `ASSERT_NXT(a_accept_starts, clk, rst, accept, busy && (cnt == '0), "accepted transaction did not start at sub-step zero")
  `ASSERT_NXT(a_last_flag, clk, rst, ctl.advance && sub_last, result_valid && last, "final sub-step did not raise last")
  `ASSERT_NXT(a_silent_mid, clk, rst, ctl.advance && cur_silent, duty == (pwm_period >> 1), "silent sub-step did not give midpoint")
  `ASSERT_IMP(a_stall_busy, clk, rst, item_stall, busy, "input stalled while idle")

endmodule

// ===== src/nspm_integ.sv =====
// Fourth-order integrator cascade with quantizer feedback, one sub-step per advance.
// Depends on nspm_pkg.
`timescale 1ns / 1ps

module nspm_integ (
  input  logic                              clk,
  input  logic                              rst,
  input  nspm_pkg::step_ctl_t               ctl,
  input  logic signed [nspm_pkg::SAMPLE_W-1:0] sample,
  output logic        [nspm_pkg::DUTY_W-1:0]   level
);
  import nspm_pkg::*;

  logic [INTEG_W-1:0] integ [4];
  logic [INTEG_W-1:0] integ_next [4];
  logic [INTEG_W-1:0] acc [4];
  logic [INTEG_W-1:0] fb;
  logic [INTEG_W-1:0] x;

  always_comb begin
    x      = {{(INTEG_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    acc[0] = integ[0] + x;
    acc[1] = integ[1] + acc[0];
    acc[2] = integ[2] + acc[1];
    acc[3] = integ[3] + acc[2];
    level  = acc[3][LEVEL_SH +: DUTY_W];
    fb     = {{(INTEG_W-DUTY_W-LEVEL_SH){level[DUTY_W-1]}}, level, {LEVEL_SH{1'b0}}};
    for (int i = 0; i < 4; i++) begin
      integ_next[i] = acc[i] - fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        integ[i] <= '0;
      end
    end else if (ctl.advance && ctl.update) begin
      for (int i = 0; i < 4; i++) begin
        integ[i] <= integ_next[i];
      end
    end
  end

endmodule
